/* hw/rtl/csp_pkg.sv */
package csp_pkg;

  localparam int PROB_FRAC_BITS = 31;
  localparam int PROB_W         = 32;
  localparam int IDX_W          = 12;
  localparam int OP_W           = 2;
  localparam int NUM_VARS_DEF   = 4096;
  localparam int IN_TDATA_W     = 48;
  localparam int OUT_TDATA_W    = 32;

  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_LOAD   = 2'd0;
  localparam op_t OP_MEMBER = 2'd1;
  localparam op_t OP_FINISH = 2'd2;

  localparam logic MODE_SUM   = 1'b0;
  localparam logic MODE_BOUND = 1'b1;

endpackage

/* hw/rtl/csp_table.sv */
module csp_table #(
  parameter int NUM_VARS = csp_pkg::NUM_VARS_DEF,
  localparam int ADDR_W = $clog2(NUM_VARS)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [csp_pkg::PROB_W-1:0] wdata,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [csp_pkg::PROB_W-1:0] rdata
);
  import csp_pkg::*;

  logic [PROB_W-1:0] mem [NUM_VARS];
  logic [PROB_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/csp_mul.sv */
module csp_mul (
  input  logic                       clk,
  input  logic [csp_pkg::PROB_W-1:0] a,
  input  logic [csp_pkg::PROB_W-1:0] b,
  output logic [csp_pkg::PROB_W-1:0] p
);
  import csp_pkg::*;

  localparam int PROD_W = 2 * PROB_W;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] shifted;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

  // truncating fixed-point scale, saturated at one
  assign shifted = prod_r >> PROB_FRAC_BITS;
  assign p = (shifted > PROD_W'(PROB_ONE)) ? PROB_ONE : shifted[PROB_W-1:0];

endmodule

/* hw/rtl/cut_set_probability_quantifier_unit.sv */
// Sequencer order: a load writes the table in S_DISPATCH; a member passes S_DISPATCH,
// S_MEMWAIT and S_MULWAIT for the registered table read and the shared multiplier, and a
// closing member in bound mode then S_BNDMUL and S_BNDWAIT; a finish registers its
// result in S_DISPATCH. Requests are taken in S_IDLE only, with no result stalled on
// out_tready; a non-power-of-two NUM_VARS below 4096 adds S_REDUCE and S_REDUCE_FIX.
// rst_n (synchronous) clears the sequencer, mode, accumulators and output valid; the
// probability table keeps its contents and must be loaded before use.
module cut_set_probability_quantifier_unit #(
  parameter int NUM_VARS = csp_pkg::NUM_VARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [csp_pkg::IN_TDATA_W-1:0]  in_tdata,  // var_index[11:0], prob_value[43:12]
  input  logic [csp_pkg::OP_W-1:0]        in_tuser,  // op[1:0]
  input  logic                            in_tlast,  // last_in_set
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [csp_pkg::OUT_TDATA_W-1:0] out_tdata, // total_prob[31:0]
  output logic [0:0]                      out_tuser, // clamped[0]
  input  logic                            cfg_we,
  input  logic                            cfg_wdata
);
  import csp_pkg::*;

  localparam int     ADDR_W      = $clog2(NUM_VARS);
  localparam bit     NEED_REDUCE = (NUM_VARS < (1 << IDX_W)) &&
                                   ((NUM_VARS & (NUM_VARS - 1)) != 0);
  localparam int     CMP_W       = 2 * IDX_W;
  localparam int     RPROD_W     = IDX_W + CMP_W;
  localparam longint RECIP       = (longint'(1) << CMP_W) / NUM_VARS;

  typedef enum logic [2:0] {
    S_IDLE, S_REDUCE, S_REDUCE_FIX, S_DISPATCH, S_MEMWAIT, S_MULWAIT, S_BNDMUL, S_BNDWAIT
  } state_t;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [IDX_W-1:0]  rem_r, rem_nxt;
  logic [PROB_W-1:0] pv_r, pv_nxt;
  logic              last_r, last_nxt;
  logic [IDX_W-1:0]  q_r, q_nxt;
  logic              mode_r, mode_nxt;
  logic [PROB_W-1:0] sp_r, sp_nxt;
  logic [PROB_W-1:0] acc_r, acc_nxt;
  logic              clamp_r, clamp_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PROB_W-1:0] total_r, total_nxt;
  logic              oclamp_r, oclamp_nxt;

  logic [PROB_W-1:0]  in_pv;
  logic [RPROD_W-1:0] recip_prod;
  logic [CMP_W-1:0]   red_diff;
  logic [PROB_W:0]    sum;
  logic [ADDR_W-1:0]  idx;
  logic               mem_we;
  logic [PROB_W-1:0]  rd_data;
  logic [PROB_W-1:0]  mul_a, mul_b, mul_p;

  csp_table #(.NUM_VARS(NUM_VARS)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx),
    .wdata (pv_r),
    .raddr (idx),
    .rdata (rd_data)
  );

  csp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_pv      = in_tdata[IDX_W +: PROB_W];
  assign idx        = ADDR_W'(rem_r);
  assign mem_we     = (state_r == S_DISPATCH) && (op_r == OP_LOAD);
  assign recip_prod = RPROD_W'(rem_r) * RPROD_W'(RECIP);
  assign red_diff   = CMP_W'(rem_r) - (CMP_W'(q_r) * CMP_W'(NUM_VARS));
  assign sum        = {1'b0, acc_r} + {1'b0, mul_p};
  assign mul_a      = (state_r == S_BNDMUL) ? acc_r : sp_r;
  assign mul_b      = (state_r == S_BNDMUL) ? (PROB_ONE - sp_r) : rd_data;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    rem_nxt       = rem_r;
    pv_nxt        = pv_r;
    last_nxt      = last_r;
    q_nxt         = q_r;
    mode_nxt      = mode_r;
    sp_nxt        = sp_r;
    acc_nxt       = acc_r;
    clamp_nxt     = clamp_r;
    out_valid_nxt = out_valid_r;
    total_nxt     = total_r;
    oclamp_nxt    = oclamp_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          op_nxt    = in_tuser;
          rem_nxt   = in_tdata[IDX_W-1:0];
          pv_nxt    = (in_pv > PROB_ONE) ? PROB_ONE : in_pv;
          last_nxt  = in_tlast;
          state_nxt = NEED_REDUCE ? S_REDUCE : S_DISPATCH;
        end
      end
      S_REDUCE: begin
        // reciprocal quotient estimate, low by at most one
        q_nxt     = recip_prod[CMP_W +: IDX_W];
        state_nxt = S_REDUCE_FIX;
      end
      S_REDUCE_FIX: begin
        if (red_diff >= CMP_W'(NUM_VARS)) begin
          rem_nxt = IDX_W'(red_diff - CMP_W'(NUM_VARS));
        end else begin
          rem_nxt = red_diff[IDX_W-1:0];
        end
        state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_nxt = S_IDLE;
        case (op_r)
          OP_MEMBER: state_nxt = S_MEMWAIT;
          OP_FINISH: begin
            out_valid_nxt = 1'b1;
            total_nxt     = (mode_r == MODE_BOUND) ? (PROB_ONE - acc_r) : acc_r;
            oclamp_nxt    = (mode_r == MODE_SUM) && clamp_r;
            sp_nxt        = PROB_ONE;
            acc_nxt       = (mode_r == MODE_BOUND) ? PROB_ONE : '0;
            clamp_nxt     = 1'b0;
          end
          default: ;
        endcase
      end
      S_MEMWAIT: begin
        state_nxt = S_MULWAIT;
      end
      S_MULWAIT: begin
        sp_nxt    = mul_p;
        state_nxt = S_IDLE;
        if (last_r) begin
          if (mode_r == MODE_SUM) begin
            sp_nxt = PROB_ONE;
            if (sum > {1'b0, PROB_ONE}) begin
              acc_nxt   = PROB_ONE;
              clamp_nxt = 1'b1;
            end else begin
              acc_nxt = sum[PROB_W-1:0];
            end
          end else begin
            state_nxt = S_BNDMUL;
          end
        end
      end
      S_BNDMUL: begin
        state_nxt = S_BNDWAIT;
      end
      S_BNDWAIT: begin
        acc_nxt   = mul_p;
        sp_nxt    = PROB_ONE;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      mode_nxt  = cfg_wdata;
      sp_nxt    = PROB_ONE;
      acc_nxt   = (cfg_wdata == MODE_BOUND) ? PROB_ONE : '0;
      clamp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_SUM;
      sp_r        <= PROB_ONE;
      acc_r       <= '0;
      clamp_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      sp_r        <= sp_nxt;
      acc_r       <= acc_nxt;
      clamp_r     <= clamp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r     <= op_nxt;
    rem_r    <= rem_nxt;
    pv_r     <= pv_nxt;
    last_r   <= last_nxt;
    q_r      <= q_nxt;
    total_r  <= total_nxt;
    oclamp_r <= oclamp_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = total_r;
  assign out_tuser  = oclamp_r;

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DISPATCH && op_r == OP_FINISH))
    else $error("result raised without a finish request");

  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r <= PROB_ONE) && (sp_r <= PROB_ONE))
    else $error("accumulator or set product above one");

  a_clamp_sum_only: assert property (@(posedge clk) disable iff (!rst_n)
    clamp_r |-> (mode_r == MODE_SUM))
    else $error("clamp flag set in bound mode");

  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BNDWAIT) |-> $past(state_r == S_BNDMUL))
    else $error("bound product taken without its multiply");

endmodule

/* dv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import csp_pkg::*;

  localparam op_t OP_NONE  = 2'd3;
  localparam int  HOLD_CYC = 300;
  localparam int  DOG_LIM  = 3000;
  localparam int  SETTLE   = 10;

  typedef struct {
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [PROB_W-1:0] pv;
    logic              last;
  } prob_req_t;

  typedef struct {
    logic [PROB_W-1:0] prob;
    logic              clamped;
  } top_total_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]        in_tuser   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   cfg_we     = 1'b0;
  logic                   cfg_wdata  = 1'b0;

  cut_set_probability_quantifier_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [PROB_W-1:0] prob_tbl [NUM_VARS_DEF];
  logic [PROB_W-1:0] set_prod = PROB_ONE;
  logic [PROB_W-1:0] top_acc  = '0;
  logic              sum_clamp = 1'b0;
  logic              mode_q    = MODE_SUM;

  prob_req_t  req_q [$];
  top_total_t total_q [$];
  prob_req_t  bus_req;

  bit          idx_loaded [NUM_VARS_DEF];
  int unsigned loaded_idx [$];

  logic calm    = 1'b0;
  logic hold_go = 1'b0;
  int   hold_left = 0;
  int   n_err = 0;
  int   n_req = 0;
  int   n_totals = 0;
  int   n_clamped = 0;
  int   dog = 0;

  function automatic logic [PROB_W-1:0] prob_mul(logic [PROB_W-1:0] a, logic [PROB_W-1:0] b);
    logic [63:0] p;
    p = ({32'b0, a} * {32'b0, b}) >> PROB_FRAC_BITS;
    return (p > 64'(PROB_ONE)) ? PROB_ONE : p[PROB_W-1:0];
  endfunction

  function automatic void clear_totals();
    set_prod  = PROB_ONE;
    top_acc   = (mode_q == MODE_BOUND) ? PROB_ONE : '0;
    sum_clamp = 1'b0;
  endfunction

  function automatic void quantify(prob_req_t r);
    logic [PROB_W:0] s;
    top_total_t      t;
    case (r.op)
      OP_LOAD: begin
        prob_tbl[r.idx] = (r.pv > PROB_ONE) ? PROB_ONE : r.pv;
      end
      OP_MEMBER: begin
        set_prod = prob_mul(set_prod, prob_tbl[r.idx]);
        if (r.last) begin
          if (mode_q == MODE_SUM) begin
            s = {1'b0, top_acc} + {1'b0, set_prod};
            if (s > {1'b0, PROB_ONE}) begin
              s = {1'b0, PROB_ONE};
              sum_clamp = 1'b1;
            end
            top_acc = s[PROB_W-1:0];
          end else begin
            top_acc = prob_mul(top_acc, PROB_ONE - set_prod);
          end
          set_prod = PROB_ONE;
        end
      end
      OP_FINISH: begin
        t.prob    = (mode_q == MODE_BOUND) ? PROB_ONE - top_acc : top_acc;
        t.clamped = (mode_q == MODE_SUM) && sum_clamp;
        total_q.insert(total_q.size(), t);
        clear_totals();
      end
      default: ;
    endcase
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s, got %h want %h", $realtime, what, got, want);
    n_err++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        quantify(bus_req);
        n_req++;
      end
      if (req_q.size() != 0 && (calm || $urandom_range(0, 99) >= 28)) begin
        bus_req = req_q.pop_front();
        in_tdata  <= IN_TDATA_W'({bus_req.pv, bus_req.idx});
        in_tuser  <= bus_req.op;
        in_tlast  <= bus_req.last;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_go) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYC;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 28);
    end
  end

  // monitor
  always @(posedge clk) begin
    top_total_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_totals++;
      if (out_tuser[0]) n_clamped++;
      if (total_q.size() == 0) begin
        report("unexpected total", out_tdata, '0);
      end else begin
        e = total_q.pop_front();
        if (out_tdata !== e.prob) report("total_prob", out_tdata, e.prob);
        if (out_tuser[0] !== e.clamped) report("clamped", 32'(out_tuser[0]), 32'(e.clamped));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        dog <= 0;
      end else if (dog >= DOG_LIM) begin
        $display("timeout: no request or total moved for %0d cycles", DOG_LIM);
        $display("tb_top NOT OK");
        $finish;
      end else begin
        dog <= dog + 1;
      end
    end
  end

  task automatic add(op_t op, logic [IDX_W-1:0] idx, logic [PROB_W-1:0] pv, logic last);
    prob_req_t r;
    r.op   = op;
    r.idx  = idx;
    r.pv   = pv;
    r.last = last;
    if (op == OP_LOAD && !idx_loaded[idx]) begin
      idx_loaded[idx] = 1'b1;
      loaded_idx.insert(loaded_idx.size(), 32'(idx));
    end
    req_q.insert(req_q.size(), r);
  endtask

  function automatic logic [PROB_W-1:0] draw_prob();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PROB_ONE;
      2:       return PROB_ONE | $urandom;
      3, 4, 5: return $urandom & 32'h7FFF_FFFF;
      default: return $urandom >> $urandom_range(3, 24);
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_idx();
    return IDX_W'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]);
  endfunction

  // checked away from the rising edge so driver updates have settled
  task automatic drain();
    @(negedge clk);
    while (req_q.size() != 0 || in_tvalid || total_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_mode(logic m);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_wdata <= m;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_q = m;
    clear_totals();
  endtask

  task automatic random_phase(int n_items);
    int cnt;
    int r;
    int m;
    cnt = 0;
    while (cnt < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        add(OP_LOAD, IDX_W'($urandom), draw_prob(), 1'($urandom));
        cnt++;
      end else if (r < 12) begin
        add(OP_NONE, IDX_W'($urandom), $urandom, 1'($urandom));
      end else if (r < 22) begin
        add(OP_FINISH, IDX_W'($urandom), $urandom, 1'($urandom));
        cnt++;
      end else begin
        // r < 26 leaves the set open
        m = $urandom_range(1, 4);
        for (int k = 0; k < m; k++)
          add(OP_MEMBER, pick_idx(), $urandom, (k == m - 1) && (r >= 26));
        cnt += m;
      end
    end
    add(OP_FINISH, IDX_W'($urandom), $urandom, 1'($urandom));
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sum mode, directed
    add(OP_FINISH, 12'h000, 32'h0, 1'b0);
    add(OP_LOAD,   12'hFFF, 32'hFFFF_FFFF, 1'b1);
    add(OP_LOAD,   12'h000, 32'h0, 1'b0);
    add(OP_LOAD,   12'hAAA, 32'h5555_5555, 1'b0);
    add(OP_LOAD,   12'h555, 32'h2AAA_AAAA, 1'b1);
    add(OP_LOAD,   12'h123, PROB_ONE + 32'd1, 1'b0);
    add(OP_NONE,   12'hFFF, 32'hFFFF_FFFF, 1'b1);
    add(OP_MEMBER, 12'hFFF, 32'h0, 1'b1);
    add(OP_MEMBER, 12'h555, 32'h0, 1'b0);
    add(OP_MEMBER, 12'hAAA, 32'h0, 1'b1);
    add(OP_FINISH, 12'h000, 32'h0, 1'b0);
    add(OP_MEMBER, 12'hAAA, 32'h0, 1'b0);
    add(OP_FINISH, 12'hFFF, 32'hFFFF_FFFF, 1'b1);
    add(OP_MEMBER, 12'h000, 32'h0, 1'b1);
    add(OP_MEMBER, 12'h555, 32'h0, 1'b1);
    add(OP_FINISH, 12'h000, 32'h0, 1'b0);
    drain();

    // bound mode, directed
    set_mode(MODE_BOUND);
    add(OP_FINISH, 12'h000, 32'h0, 1'b0);
    add(OP_MEMBER, 12'hAAA, 32'h0, 1'b0);
    add(OP_MEMBER, 12'h555, 32'h0, 1'b1);
    add(OP_MEMBER, 12'h123, 32'h0, 1'b1);
    add(OP_FINISH, 12'h000, 32'h0, 1'b1);
    add(OP_MEMBER, 12'h555, 32'h0, 1'b0);
    // open set is dropped by the mode write
    set_mode(MODE_SUM);
    add(OP_FINISH, 12'h000, 32'h0, 1'b0);
    drain();

    for (int i = 0; i < 48; i++)
      add(OP_LOAD, IDX_W'($urandom), draw_prob(), 1'($urandom));

    random_phase(100);

    set_mode(MODE_BOUND);
    calm <= 1'b1;
    random_phase(100);
    calm <= 1'b0;

    // long receiver hold with finishes queued up behind it
    set_mode(MODE_SUM);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (int i = 0; i < 12; i++)
      add(OP_FINISH, IDX_W'($urandom), $urandom, 1'($urandom));
    random_phase(80);

    set_mode(MODE_BOUND);
    random_phase(100);
    set_mode(MODE_BOUND);
    random_phase(70);
    set_mode(MODE_SUM);
    random_phase(90);

    repeat (SETTLE) @(posedge clk);
    if (total_q.size() != 0) report("totals never produced", 32'(total_q.size()), '0);

    $display("run: %0d requests in sum and bound modes, %0d totals checked, %0d clamped",
             n_req, n_totals, n_clamped);
    $display("includes open sets, saturating loads, ignored op codes and a long output hold");
    if (n_err == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
